/* hw/rtl/plt_pkg.sv */
// Shared types and constants for the pivot level touch detector.
`timescale 1ns / 1ps

package plt_pkg;

    typedef struct packed {
        logic [7:0]  window_length;
        logic [23:0] tick_size;
        logic [7:0]  max_ticks;
    } t_cfg;

    localparam int          PADDR_W        = 4;
    localparam logic [1:0]  REG_WINDOW     = 2'd0;
    localparam logic [1:0]  REG_TICK       = 2'd1;
    localparam logic [1:0]  REG_MAX_TICKS  = 2'd2;

    localparam logic [7:0]  DEFAULT_WINDOW = 8'd96;
    localparam logic [23:0] DEFAULT_TICK   = 24'd256;
    localparam logic [7:0]  MIN_WINDOW     = 8'd2;
    localparam logic [7:0]  BARS_SAT       = 8'd255;

    localparam logic [7:0]  RST_WINDOW     = 8'd96;
    localparam logic [23:0] RST_TICK       = 24'd256;
    localparam logic [7:0]  RST_MAX_TICKS  = 8'd3;

endpackage

/* hw/rtl/plt_fifo.sv */
// Two-entry queue between the front and back sections.
`timescale 1ns / 1ps

module plt_fifo #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [DW-1:0] o_pop_data,
    output logic          o_empty
);

    logic [DW-1:0] r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          n_wr_ptr;
    logic          n_rd_ptr;
    logic [1:0]    n_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_full     = (r_count == 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign push_ok    = i_push && !o_full;
    assign pop_ok     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push_ok ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop_ok ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 2'd1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

/* hw/rtl/plt_front.sv */
// Front section: accepts bars, tracks history depth and ring slot, sizes the window.
`timescale 1ns / 1ps

module plt_front #(
    parameter int WINDOW_MAX = 128,
    parameter int PRICE_BITS = 32,
    parameter int AW         = $clog2(WINDOW_MAX),
    parameter int CW         = $clog2(WINDOW_MAX + 1),
    parameter int JW         = 3 * PRICE_BITS + CW + AW + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  plt_pkg::t_cfg         i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PRICE_BITS-1:0] i_bar_high,
    input  logic [PRICE_BITS-1:0] i_bar_low,
    input  logic [PRICE_BITS-1:0] i_bar_close,
    output logic                  o_push,
    output logic [JW-1:0]         o_push_data,
    input  logic                  i_full
);

    logic [7:0]    r_bars;
    logic [AW-1:0] r_wptr;
    logic [7:0]    w_eff;
    logic [7:0]    w_min;
    logic [CW-1:0] cnt;
    logic          rdy;
    logic          accept;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign o_push     = accept;

    always_comb begin
        w_eff = (i_cfg.window_length < plt_pkg::MIN_WINDOW) ?
                plt_pkg::DEFAULT_WINDOW : i_cfg.window_length;
        w_min = (r_bars < w_eff) ? r_bars : w_eff;
        if ({24'd0, w_min} > 32'(WINDOW_MAX)) begin
            cnt = CW'(WINDOW_MAX);
        end else begin
            cnt = CW'(w_min);
        end
        rdy = (r_bars >= 8'd2);
    end

    assign o_push_data = {rdy, r_wptr, cnt, i_bar_close, i_bar_low, i_bar_high};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bars <= 8'd0;
            r_wptr <= '0;
        end else if (accept) begin
            if (r_bars != plt_pkg::BARS_SAT) begin
                r_bars <= r_bars + 8'd1;
            end
            r_wptr <= (r_wptr == AW'(WINDOW_MAX - 1)) ? '0 : r_wptr + AW'(1);
        end
    end

    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_wptr) < WINDOW_MAX)
        else $error("ring slot out of range");

    a_ready_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && rdy) |-> (cnt >= CW'(2)))
        else $error("ready bar with window below two");

    a_bars_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (r_bars != plt_pkg::BARS_SAT) |=> (r_bars == $past(r_bars) + 8'd1))
        else $error("bar count did not advance");

endmodule

/* hw/rtl/plt_back.sv */
// Back section: scans the high/low ring, forms S1/R1 and tests for a touch.
`timescale 1ns / 1ps

module plt_back #(
    parameter int WINDOW_MAX = 128,
    parameter int PRICE_BITS = 32,
    parameter int AW         = $clog2(WINDOW_MAX),
    parameter int CW         = $clog2(WINDOW_MAX + 1),
    parameter int JW         = 3 * PRICE_BITS + CW + AW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  plt_pkg::t_cfg i_cfg,
    input  logic          i_empty,
    input  logic [JW-1:0] i_pop_data,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_touch,
    output logic          o_ready_res
);

    localparam int P    = PRICE_BITS;
    localparam int SW   = P + 4;
    localparam int AB   = P + 3;
    localparam int CMPW = (AB > 34) ? AB : 34;
    localparam int XW   = CW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_CALC1,
        S_CALC2,
        S_FIN
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_k;
    logic [P-1:0]    r_hi;
    logic [P-1:0]    r_lo;
    logic [P-1:0]    r_cl;
    logic [AW-1:0]   r_wptr;
    logic [CW-1:0]   r_cnt;
    logic            r_rdy;
    logic [P-1:0]    r_prev;
    logic [P-1:0]    r_hmax;
    logic [P-1:0]    r_lmin;
    logic            r_rd_vld;
    logic [P-1:0]    r_rd_h;
    logic [P-1:0]    r_rd_l;
    logic signed [SW-1:0] r_ds;
    logic signed [SW-1:0] r_dr;
    logic [31:0]     r_prod;
    logic [AB-1:0]   r_ads;
    logic [AB-1:0]   r_adr;
    logic [33:0]     r_tol;
    logic            r_out_valid;
    logic            r_touch;
    logic            r_ready_res;

    logic [P-1:0]    mem_h [WINDOW_MAX];
    logic [P-1:0]    mem_l [WINDOW_MAX];

    logic            q_rdy;
    logic [AW-1:0]   q_wptr;
    logic [CW-1:0]   q_cnt;
    logic [P-1:0]    q_cl;
    logic [P-1:0]    q_lo;
    logic [P-1:0]    q_hi;
    logic [XW-1:0]   rd_tmp;
    logic [XW-1:0]   rd_wrap;
    logic [AW-1:0]   rd_addr;
    logic            fin_go;
    logic            wr_en;
    logic [23:0]     tk;
    logic signed [SW-1:0] c_h;
    logic signed [SW-1:0] c_l;
    logic signed [SW-1:0] c_c;
    logic signed [SW-1:0] c_x;
    logic            hit;

    assign {q_rdy, q_wptr, q_cnt, q_cl, q_lo, q_hi} = i_pop_data;

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign fin_go      = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign wr_en       = fin_go;
    assign o_out_valid = r_out_valid;
    assign o_touch     = r_touch;
    assign o_ready_res = r_ready_res;

    always_comb begin
        rd_tmp  = XW'(r_wptr) + XW'(WINDOW_MAX - 1) - XW'(r_k);
        rd_wrap = (rd_tmp >= XW'(WINDOW_MAX)) ? rd_tmp - XW'(WINDOW_MAX) : rd_tmp;
        rd_addr = rd_wrap[AW-1:0];
        tk      = (i_cfg.tick_size == 24'd0) ? plt_pkg::DEFAULT_TICK : i_cfg.tick_size;
        c_h     = $signed({4'b0, r_hmax});
        c_l     = $signed({4'b0, r_lmin});
        c_c     = $signed({4'b0, r_prev});
        c_x     = $signed({4'b0, r_cl});
        hit     = r_rdy && ((CMPW'(r_ads) <= CMPW'(r_tol)) || (CMPW'(r_adr) <= CMPW'(r_tol)));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_h[r_wptr] <= r_hi;
            mem_l[r_wptr] <= r_lo;
        end
        r_rd_h <= mem_h[rd_addr];
        r_rd_l <= mem_l[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_rdy       <= 1'b0;
            r_prev      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_touch     <= 1'b0;
            r_ready_res <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN);
            if (r_rd_vld) begin
                if (r_rd_h > r_hmax) begin
                    r_hmax <= r_rd_h;
                end
                if (r_rd_l < r_lmin) begin
                    r_lmin <= r_rd_l;
                end
            end
            if (r_out_valid && i_out_ready && !fin_go) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_hi   <= q_hi;
                        r_lo   <= q_lo;
                        r_cl   <= q_cl;
                        r_wptr <= q_wptr;
                        r_cnt  <= q_cnt;
                        r_rdy  <= q_rdy;
                        r_k    <= '0;
                        r_hmax <= '0;
                        r_lmin <= '1;
                        r_state <= q_rdy ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    r_k <= r_k + CW'(1);
                    if (r_k == r_cnt - CW'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_CALC1;
                end
                S_CALC1: begin
                    r_ds    <= (c_x <<< 1) + c_x + c_h - (c_l <<< 1) - (c_c <<< 1);
                    r_dr    <= (c_x <<< 1) + c_x + c_l - (c_h <<< 1) - (c_c <<< 1);
                    r_prod  <= {24'd0, i_cfg.max_ticks} * {8'd0, tk};
                    r_state <= S_CALC2;
                end
                S_CALC2: begin
                    r_ads   <= r_ds[SW-1] ? AB'(-r_ds) : AB'(r_ds);
                    r_adr   <= r_dr[SW-1] ? AB'(-r_dr) : AB'(r_dr);
                    r_tol   <= {2'b0, r_prod} + {1'b0, r_prod, 1'b0};
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_out_valid <= 1'b1;
                        r_touch     <= hit;
                        r_ready_res <= r_rdy;
                        r_prev      <= r_cl;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k < r_cnt))
        else $error("scan index past window");

    a_scan_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rdy && (r_cnt >= CW'(2))))
        else $error("scan without enough history");

    a_no_touch_unready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ready_res) |-> !r_touch)
        else $error("touch flagged without history");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE))
        else $error("popped beat not taken");

endmodule

/* hw/rtl/pivot_level_touch_detector_top.sv */
// Top level of the pivot level touch detector: register port and section wiring.
//
// channel   | handshake                  | payload
// ----------+----------------------------+----------------------------------------
// bar in    | i_in_valid / o_in_ready    | i_bar_high, i_bar_low, i_bar_close
// result    | o_out_valid / i_out_ready  | o_touch, o_ready_res
// registers | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// Each beat scans min(window, bars seen, WINDOW_MAX) ring entries once two bars exist, none before;
// the window scan reads one ring entry per cycle from a single read port.
// Reset is synchronous, active low; the ring needs no clearing pass.
// A two-deep queue lets bars enter while the back section scans or the result stalls.
`timescale 1ns / 1ps

module pivot_level_touch_detector_top #(
    parameter int WINDOW_MAX = 128,
    parameter int PRICE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [PRICE_BITS-1:0]        i_bar_high,
    input  logic [PRICE_BITS-1:0]        i_bar_low,
    input  logic [PRICE_BITS-1:0]        i_bar_close,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_touch,
    output logic                         o_ready_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [plt_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int JW = 3 * PRICE_BITS + CW + AW + 1;

    plt_pkg::t_cfg r_cfg;
    logic          wr_stb;
    logic          q_push;
    logic [JW-1:0] q_push_data;
    logic          q_full;
    logic          q_pop;
    logic [JW-1:0] q_pop_data;
    logic          q_empty;

    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length <= plt_pkg::RST_WINDOW;
            r_cfg.tick_size     <= plt_pkg::RST_TICK;
            r_cfg.max_ticks     <= plt_pkg::RST_MAX_TICKS;
        end else if (wr_stb) begin
            case (paddr[3:2])
                plt_pkg::REG_WINDOW:    r_cfg.window_length <= pwdata[7:0];
                plt_pkg::REG_TICK:      r_cfg.tick_size     <= pwdata[23:0];
                plt_pkg::REG_MAX_TICKS: r_cfg.max_ticks     <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            plt_pkg::REG_WINDOW:    prdata = {24'd0, r_cfg.window_length};
            plt_pkg::REG_TICK:      prdata = {8'd0, r_cfg.tick_size};
            plt_pkg::REG_MAX_TICKS: prdata = {24'd0, r_cfg.max_ticks};
            default:                prdata = 32'd0;
        endcase
    end

    plt_front #(
        .WINDOW_MAX (WINDOW_MAX),
        .PRICE_BITS (PRICE_BITS),
        .AW         (AW),
        .CW         (CW),
        .JW         (JW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_bar_high  (i_bar_high),
        .i_bar_low   (i_bar_low),
        .i_bar_close (i_bar_close),
        .o_push      (q_push),
        .o_push_data (q_push_data),
        .i_full      (q_full)
    );

    plt_fifo #(
        .DW (JW)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_empty     (q_empty)
    );

    plt_back #(
        .WINDOW_MAX (WINDOW_MAX),
        .PRICE_BITS (PRICE_BITS),
        .AW         (AW),
        .CW         (CW),
        .JW         (JW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (q_empty),
        .i_pop_data  (q_pop_data),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_touch     (o_touch),
        .o_ready_res (o_ready_res)
    );

endmodule

/* sim/pivot_level_touch_detector_top_test.sv */
// Self-checking testbench for the pivot level touch detector top level.
`timescale 1ns / 1ps

module pivot_level_touch_detector_top_test;

    localparam int     RING_DEPTH   = 128;
    localparam int     MIN_HISTORY  = 2;
    localparam int     SHOW_LIMIT   = 10;
    localparam int     SCAN_LATENCY = RING_DEPTH + 8;
    localparam int     QUIET_LIMIT  = 3000;
    localparam int     PHASE_BARS   = 76;
    localparam longint PRICE_MAX    = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic touch;
        logic ready_res;
    } t_pivot_flags;

    typedef enum logic [1:0] {CLOSE_INSIDE, CLOSE_AT_S1, CLOSE_AT_R1} t_close_kind;

    class pivot_touch_scoreboard;
        longint       high_hist [RING_DEPTH];
        longint       low_hist [RING_DEPTH];
        longint       last_close;
        logic [6:0]   wr_ptr;
        logic [7:0]   bars_count;
        logic [7:0]   window_reg;
        logic [23:0]  tick_reg;
        logic [7:0]   tol_ticks_reg;
        t_pivot_flags expected_flags [$];
        int           mismatches;

        function new();
            foreach (high_hist[i]) begin
                high_hist[i] = 0;
                low_hist[i]  = 0;
            end
            last_close    = 0;
            wr_ptr        = '0;
            bars_count    = '0;
            window_reg    = plt_pkg::RST_WINDOW;
            tick_reg      = plt_pkg::RST_TICK;
            tol_ticks_reg = plt_pkg::RST_MAX_TICKS;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                plt_pkg::REG_WINDOW:    window_reg    = value[7:0];
                plt_pkg::REG_TICK:      tick_reg      = value[23:0];
                plt_pkg::REG_MAX_TICKS: tol_ticks_reg = value[7:0];
                default: ;
            endcase
        endfunction

        function longint tolerance_x3();
            longint tick;
            longint ticks;
            tick  = (tick_reg == '0) ? plt_pkg::DEFAULT_TICK : tick_reg;
            ticks = tol_ticks_reg;
            return 3 * ticks * tick;
        endfunction

        function void touch_levels_x3(output longint s1x3, output longint r1x3);
            int     win;
            int     span;
            int     slot;
            longint hmax;
            longint lmin;
            win = (window_reg < plt_pkg::MIN_WINDOW) ? plt_pkg::DEFAULT_WINDOW : window_reg;
            if (win > RING_DEPTH) win = RING_DEPTH;
            span = (int'(bars_count) < win) ? int'(bars_count) : win;
            hmax = 0;
            lmin = PRICE_MAX;
            for (int k = 0; k < span; k++) begin
                slot = (int'(wr_ptr) + RING_DEPTH - 1 - k) % RING_DEPTH;
                if (high_hist[slot] > hmax) hmax = high_hist[slot];
                if (low_hist[slot] < lmin) lmin = low_hist[slot];
            end
            s1x3 = 2 * lmin + 2 * last_close - hmax;
            r1x3 = 2 * hmax + 2 * last_close - lmin;
        endfunction

        function void note_bar(logic [31:0] bar_h, logic [31:0] bar_l, logic [31:0] bar_c);
            t_pivot_flags flags;
            longint       s1x3;
            longint       r1x3;
            longint       c3;
            longint       dist_s;
            longint       dist_r;
            flags = '0;
            if (bars_count >= MIN_HISTORY) begin
                touch_levels_x3(s1x3, r1x3);
                c3 = bar_c;
                c3 = 3 * c3;
                dist_s = (c3 > s1x3) ? c3 - s1x3 : s1x3 - c3;
                dist_r = (c3 > r1x3) ? c3 - r1x3 : r1x3 - c3;
                flags.touch     = (((dist_s < dist_r) ? dist_s : dist_r) <= tolerance_x3());
                flags.ready_res = 1'b1;
            end
            expected_flags.push_back(flags);
            high_hist[wr_ptr] = bar_h;
            low_hist[wr_ptr]  = bar_l;
            wr_ptr            = wr_ptr + 1'b1;
            last_close        = bar_c;
            if (bars_count != plt_pkg::BARS_SAT) bars_count = bars_count + 1'b1;
        endfunction

        function void flag_error(string what);
            mismatches++;
            if (mismatches <= SHOW_LIMIT) $display("%s", what);
        endfunction

        function void check_result(logic touch, logic ready_res);
            t_pivot_flags flags;
            if (expected_flags.size() == 0) begin
                flag_error($sformatf("result beat with no bar pending: touch=%0b ready_res=%0b",
                                     touch, ready_res));
                return;
            end
            flags = expected_flags.pop_front();
            if (touch !== flags.touch || ready_res !== flags.ready_res)
                flag_error($sformatf({"result mismatch: expected touch=%0b ready_res=%0b, ",
                                      "got touch=%0b ready_res=%0b"},
                                     flags.touch, flags.ready_res, touch, ready_res));
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction

        function int finish();
            if (expected_flags.size() != 0)
                flag_error($sformatf("%0d bars left without a result", expected_flags.size()));
            return mismatches;
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [31:0]                  i_bar_high;
    logic [31:0]                  i_bar_low;
    logic [31:0]                  i_bar_close;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic                         o_touch;
    logic                         o_ready_res;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [plt_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    pivot_touch_scoreboard board;
    int                    burst_left;
    bit                    steady_send;
    longint                mid_price;
    int                    bar_span;
    int                    rx_cycle;
    int                    stall_left;
    int                    quiet_cycles;

    pivot_level_touch_detector_top DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_result(o_touch, o_ready_res);
        rx_cycle++;
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else case ((rx_cycle / 700) % 4)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= ((rx_cycle % 11) < 6);
            default: begin
                if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 60);
                i_out_ready <= (stall_left == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [31:0] to_price(longint v);
        if (v < 0) return '0;
        if (v > PRICE_MAX) return '1;
        return v[31:0];
    endfunction

    function automatic longint close_offset();
        longint tol;
        longint sgn;
        tol = board.tolerance_x3() / 3;
        sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
        case ($urandom_range(0, 4))
            0: return 0;
            1: return sgn * tol;
            2: return sgn * (tol + 1);
            default: return sgn * longint'($urandom_range(0, 1000)) * (tol + 4) / 800;
        endcase
    endfunction

    task automatic send_bar(input logic [31:0] bar_h, input logic [31:0] bar_l,
                            input logic [31:0] bar_c);
        int idle;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            idle = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (idle > 0) begin
                i_in_valid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_bar_high  <= bar_h;
        i_bar_low   <= bar_l;
        i_bar_close <= bar_c;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_bar(bar_h, bar_l, bar_c);
    endtask

    task automatic send_shaped(input t_close_kind kind, input longint offset);
        longint h;
        longint l;
        longint c;
        longint s1x3;
        longint r1x3;
        mid_price = mid_price + longint'($urandom_range(0, 64)) - 32;
        h = mid_price + longint'($urandom_range(0, bar_span));
        l = mid_price - longint'($urandom_range(0, bar_span));
        if (kind != CLOSE_INSIDE && board.bars_count >= MIN_HISTORY) begin
            board.touch_levels_x3(s1x3, r1x3);
            c = ((kind == CLOSE_AT_S1) ? s1x3 : r1x3) / 3 + offset;
        end else begin
            c = l + longint'($urandom_range(0, int'(h - l)));
        end
        send_bar(to_price(h), to_price(l), to_price(c));
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SCAN_LATENCY) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [7:0] win, input logic [23:0] tick,
                             input logic [7:0] ticks, input int bars);
        int pick;
        settle();
        cfg_write(plt_pkg::REG_WINDOW, 32'(win));
        cfg_write(plt_pkg::REG_TICK, 32'(tick));
        cfg_write(plt_pkg::REG_MAX_TICKS, 32'(ticks));
        steady_send = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
            0: mid_price = $urandom_range(0, 4096);
            1: mid_price = PRICE_MAX - longint'($urandom_range(0, 4096));
            default: mid_price = $urandom_range(65536, 32'hFFFF_0000);
        endcase
        bar_span = $urandom_range(16, 65536);
        repeat (bars) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) send_bar($urandom, $urandom, $urandom);
            else if (pick < 50) send_shaped(CLOSE_INSIDE, 0);
            else if (pick < 75) send_shaped(CLOSE_AT_S1, close_offset());
            else send_shaped(CLOSE_AT_R1, close_offset());
        end
    endtask

    initial begin
        longint tol;
        board        = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_bar_high  <= '0;
        i_bar_low   <= '0;
        i_bar_close <= '0;
        i_out_ready <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        burst_left   = 0;
        steady_send  = 1'b0;
        mid_price    = 100 * 256;
        bar_span     = 1024;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        repeat (4) send_shaped(CLOSE_INSIDE, 0);
        tol = board.tolerance_x3() / 3;
        send_shaped(CLOSE_AT_S1, 0);
        send_shaped(CLOSE_AT_S1, tol);
        send_shaped(CLOSE_AT_S1, tol + 1);
        send_shaped(CLOSE_AT_S1, -tol);
        send_shaped(CLOSE_AT_S1, -tol - 1);
        send_shaped(CLOSE_AT_R1, 0);
        send_shaped(CLOSE_AT_R1, tol);
        send_shaped(CLOSE_AT_R1, tol + 1);
        send_shaped(CLOSE_AT_R1, -tol);
        send_shaped(CLOSE_AT_R1, -tol - 1);
        send_bar('0, '0, '0);
        send_bar('1, '1, '1);
        send_bar('1, '0, '0);
        send_bar('0, '1, '1);
        send_bar('1, '1, '0);
        send_bar('0, '0, '1);

        run_phase(8'd2, 24'd1, 8'd0, PHASE_BARS);
        run_phase(8'd0, 24'd0, 8'd255, PHASE_BARS);
        run_phase(8'd255, 24'hFF_FFFF, 8'd1, PHASE_BARS);
        run_phase(8'd128, 24'd256, 8'd3, PHASE_BARS);
        run_phase(8'd1, 24'd100, 8'd10, PHASE_BARS);
        repeat (4)
            run_phase(8'($urandom_range(2, 24)), 24'($urandom_range(1, 2048)),
                      8'($urandom_range(0, 16)), PHASE_BARS);

        settle();
        if (board.finish() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
